/* sv/rcc_pkg.sv */
// Shared types and constants for the RGB 3x3 convolution block.
// Used by every module of the block; depends on nothing.
package rcc_pkg;

  localparam int MAX_WIDTH_DEF          = 2048;
  localparam int MAX_HEIGHT_DEF         = 2048;
  localparam int KERNEL_SIZE_DEF        = 3;
  localparam int COEF_FRACTION_BITS_DEF = 12;

  localparam int DIM_W      = 12;
  localparam int COEF_W     = 16;
  localparam int KROW_W     = 3 * COEF_W;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int TAPS       = 9;
  localparam int PROD_W     = CH_W + 1 + COEF_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int SUM_W      = RSUM_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;

  localparam logic [KROW_W-1:0] KTOP_RESET = 48'h0;
  localparam logic [KROW_W-1:0] KMID_RESET = 48'h0000_1000_0000;
  localparam logic [KROW_W-1:0] KBOT_RESET = 48'h0;
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 12'd1024;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 12'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [KROW_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] win;
    logic                       top_off;
    logic                       bot_off;
    logic                       left_off;
    logic                       right_off;
    logic                       frame_end;
  } win_item_t;

  typedef struct packed {
    logic busy;
    logic inflight;
  } front_stat_t;

endpackage

/* sv/rcc_front.sv */
// Front part: frame position tracking, line stores and 3x3 window.
// Classifies each item and pushes finished windows to the queue; uses rcc_pkg.
module rcc_front #(
  parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rcc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcc_pkg::cfg_wr_t             cfg,
  input  logic                         acc,
  input  logic                         cmd,
  input  logic [rcc_pkg::PIX_W-1:0]    pix,
  output logic                         push,
  output rcc_pkg::win_item_t           push_item,
  output rcc_pkg::front_stat_t         stat
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int BI_W  = $clog2(POS_W);

  typedef enum logic [1:0] {ST_WAIT, ST_CHECK, ST_DIV, ST_RUN} state_t;

  logic [rcc_pkg::DIM_W-1:0] width_r, height_r;
  logic [WD_W-1:0]  w_eff_r, w_nxt;
  logic [HD_W-1:0]  h_eff_r, h_nxt;
  logic [POS_W-1:0] total_r;
  logic [POS_W:0]   limit;

  state_t           state_r;
  logic [1:0]       wait_r;
  logic [POS_W-1:0] pos_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [BI_W-1:0]  bit_r;
  logic [WD_W:0]    rem_r, rem_sh, rem_nxt;
  logic [POS_W-1:0] quo_r;
  logic             ge;

  logic drain, drop, go, emit, fend, col_last;
  logic [ROW_W-1:0] qr;
  logic [COL_W-1:0] qc;
  logic [rcc_pkg::PIX_W-1:0] bot;

  logic [rcc_pkg::PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0] mid_rd_r, up_rd_r, fwd_d_r;

  logic             s1_v_r;
  logic [COL_W-1:0] s1_col_r;
  logic [rcc_pkg::PIX_W-1:0] s1_bot_r;
  logic s1_mid_on_r, s1_top_on_r, s1_emit_r, s1_fend_r, s1_fwd_r;
  logic s1_top_off_r, s1_bot_off_r, s1_left_off_r, s1_right_off_r;
  logic [rcc_pkg::PIX_W-1:0] mid_val, top_val;
  logic [rcc_pkg::TAPS-1:0][rcc_pkg::PIX_W-1:0] win_r, win_nxt;

  // geometry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rcc_pkg::WIDTH_RESET;
      height_r <= rcc_pkg::HEIGHT_RESET;
    end else if (cfg.we && cfg.idx == rcc_pkg::REG_WIDTH) begin
      width_r <= cfg.data[rcc_pkg::DIM_W-1:0];
    end else if (cfg.we && cfg.idx == rcc_pkg::REG_HEIGHT) begin
      height_r <= cfg.data[rcc_pkg::DIM_W-1:0];
    end
  end

  always_comb begin
    w_nxt = WD_W'(MAX_WIDTH);
    if (width_r == '0) w_nxt = WD_W'(1);
    else if (32'(width_r) < 32'(MAX_WIDTH)) w_nxt = WD_W'(width_r);
    h_nxt = HD_W'(MAX_HEIGHT);
    if (height_r == '0) h_nxt = HD_W'(1);
    else if (32'(height_r) < 32'(MAX_HEIGHT)) h_nxt = HD_W'(height_r);
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_nxt;
    h_eff_r <= h_nxt;
    total_r <= POS_W'(w_eff_r) * POS_W'(h_eff_r);
  end

  assign limit = (POS_W + 1)'(total_r) + (POS_W + 1)'(w_eff_r);

  // item classification
  always_comb begin
    drain    = pos_r >= total_r;
    drop     = !drain && cmd;
    go       = acc && !drop && state_r == ST_RUN;
    emit     = pos_r > POS_W'(w_eff_r);
    fend     = emit && (POS_W + 1)'(pos_r) == limit;
    col_last = WD_W'(col_r) + WD_W'(1) == w_eff_r;
    qr       = (col_r != '0) ? row_r - ROW_W'(1) : row_r - ROW_W'(2);
    qc       = (col_r != '0) ? col_r - COL_W'(1) : COL_W'(w_eff_r - WD_W'(1));
    bot      = drain ? '0 : pix;
    rem_sh   = {rem_r[WD_W-1:0], pos_r[bit_r]};
    ge       = rem_sh >= (WD_W + 1)'(w_eff_r);
    rem_nxt  = ge ? rem_sh - (WD_W + 1)'(w_eff_r) : rem_sh;
  end

  // position tracking and recompute after a geometry write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      wait_r  <= '1;
      pos_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      bit_r   <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
    end else if (cfg.we && (cfg.idx == rcc_pkg::REG_WIDTH ||
                            cfg.idx == rcc_pkg::REG_HEIGHT)) begin
      state_r <= ST_WAIT;
      wait_r  <= '1;
    end else begin
      case (state_r)
        ST_WAIT: begin
          wait_r <= wait_r - 2'd1;
          if (wait_r == 2'd0) state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if ((POS_W + 1)'(pos_r) > limit) begin
            pos_r   <= '0;
            row_r   <= '0;
            col_r   <= '0;
            state_r <= ST_RUN;
          end else begin
            bit_r   <= BI_W'(POS_W - 1);
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[POS_W-2:0], ge};
          bit_r <= bit_r - BI_W'(1);
          if (bit_r == '0) begin
            row_r   <= ROW_W'({quo_r[POS_W-2:0], ge});
            col_r   <= COL_W'(rem_nxt);
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (go) begin
            if (fend) begin
              pos_r <= '0;
              row_r <= '0;
              col_r <= '0;
            end else begin
              pos_r <= pos_r + POS_W'(1);
              if (col_last) begin
                col_r <= '0;
                row_r <= row_r + ROW_W'(1);
              end else begin
                col_r <= col_r + COL_W'(1);
              end
            end
          end
        end
        default: state_r <= ST_WAIT;
      endcase
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (go) begin
      mid_rd_r       <= mid_mem[col_r];
      up_rd_r        <= up_mem[col_r];
      mid_mem[col_r] <= bot;
    end
    if (s1_v_r) up_mem[s1_col_r] <= mid_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= go;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_col_r       <= col_r;
      s1_bot_r       <= bot;
      s1_mid_on_r    <= row_r != '0;
      s1_top_on_r    <= row_r >= ROW_W'(2);
      s1_emit_r      <= emit;
      s1_fend_r      <= fend;
      s1_fwd_r       <= s1_v_r && s1_col_r == col_r;
      fwd_d_r        <= mid_val;
      s1_top_off_r   <= qr == '0;
      s1_bot_off_r   <= (ROW_W + 1)'(qr) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(h_eff_r);
      s1_left_off_r  <= qc == '0;
      s1_right_off_r <= WD_W'(qc) + WD_W'(1) >= w_eff_r;
    end
  end

  // window shift
  always_comb begin
    mid_val = s1_mid_on_r ? mid_rd_r : '0;
    top_val = s1_top_on_r ? (s1_fwd_r ? fwd_d_r : up_rd_r) : '0;
    win_nxt = win_r;
    for (int a = 0; a < 3; a++) begin
      win_nxt[a*3]     = win_r[a*3 + 1];
      win_nxt[a*3 + 1] = win_r[a*3 + 2];
    end
    win_nxt[2] = top_val;
    win_nxt[5] = mid_val;
    win_nxt[8] = s1_bot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      win_r <= '0;
    else if (s1_v_r) win_r <= win_nxt;
  end

  assign push                = s1_v_r && s1_emit_r;
  assign push_item.win       = win_nxt;
  assign push_item.top_off   = s1_top_off_r;
  assign push_item.bot_off   = s1_bot_off_r;
  assign push_item.left_off  = s1_left_off_r;
  assign push_item.right_off = s1_right_off_r;
  assign push_item.frame_end = s1_fend_r;
  assign stat.busy           = state_r != ST_RUN;
  assign stat.inflight       = s1_v_r;

endmodule

/* sv/rcc_fifo.sv */
// Short queue of finished windows between the front and back parts.
// Uses rcc_pkg for the item type and depth.
module rcc_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  rcc_pkg::win_item_t          push_item,
  input  logic                        pop,
  output logic                        not_empty,
  output rcc_pkg::win_item_t          head,
  output logic [rcc_pkg::CNT_W-1:0]   count
);

  localparam int PTR_W = $clog2(rcc_pkg::FIFO_DEPTH);

  rcc_pkg::win_item_t mem [rcc_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [rcc_pkg::CNT_W-1:0] cnt_r;
  logic do_pop;

  assign do_pop = pop && cnt_r != '0;

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wr_r <= wr_r + PTR_W'(1);
      if (do_pop) rd_r <= rd_r + PTR_W'(1);
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + rcc_pkg::CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - rcc_pkg::CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = mem[rd_r];
  assign count     = cnt_r;

endmodule

/* sv/rcc_back.sv */
// Back part: per-channel 3x3 multiply-accumulate, shift and clamp, output register.
// Holds the kernel registers; uses rcc_pkg.
module rcc_back #(
  parameter int KERNEL_SIZE        = rcc_pkg::KERNEL_SIZE_DEF,
  parameter int COEF_FRACTION_BITS = rcc_pkg::COEF_FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rcc_pkg::cfg_wr_t           cfg,
  input  logic                       q_valid,
  input  rcc_pkg::win_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rcc_pkg::PIX_W-1:0]  out_tdata,
  output logic                       out_tlast
);

  localparam int KLO = 1 - KERNEL_SIZE / 2;
  localparam int KHI = KLO + KERNEL_SIZE - 1;

  logic [2:0][rcc_pkg::KROW_W-1:0] krow_r;
  logic en;
  logic [rcc_pkg::TAPS-1:0] tap_on;

  logic signed [rcc_pkg::PROD_W-1:0] prod_r [3][rcc_pkg::TAPS];
  logic signed [rcc_pkg::RSUM_W-1:0] rsum_r [3][3];
  logic signed [rcc_pkg::SUM_W-1:0]  sum [3];
  logic [rcc_pkg::SUM_W-1:0]         shf [3];
  logic [rcc_pkg::CH_W-1:0]          clamp [3];
  logic b1_v_r, b2_v_r, o_v_r, b1_fe_r, b2_fe_r, o_fe_r;
  logic [rcc_pkg::PIX_W-1:0] o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r[0] <= rcc_pkg::KTOP_RESET;
      krow_r[1] <= rcc_pkg::KMID_RESET;
      krow_r[2] <= rcc_pkg::KBOT_RESET;
    end else if (cfg.we) begin
      case (cfg.idx)
        rcc_pkg::REG_KTOP: krow_r[0] <= cfg.data;
        rcc_pkg::REG_KMID: krow_r[1] <= cfg.data;
        rcc_pkg::REG_KBOT: krow_r[2] <= cfg.data;
        default:           krow_r    <= krow_r;
      endcase
    end
  end

  assign en    = !o_v_r || out_tready;
  assign q_pop = en && q_valid;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        tap_on[a*3 + b] = !(a < KLO || a > KHI || b < KLO || b > KHI)
                          && !(a == 0 && q_item.top_off) && !(a == 2 && q_item.bot_off)
                          && !(b == 0 && q_item.left_off) && !(b == 2 && q_item.right_off);
      end
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < rcc_pkg::TAPS; t++) begin
          if (tap_on[t]) begin
            prod_r[c][t] <= $signed({1'b0, q_item.win[t][c*rcc_pkg::CH_W +: rcc_pkg::CH_W]})
                          * $signed(krow_r[t/3][(t%3)*rcc_pkg::COEF_W +: rcc_pkg::COEF_W]);
          end else begin
            prod_r[c][t] <= '0;
          end
        end
      end
      b1_fe_r <= q_item.frame_end;
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          rsum_r[c][a] <= rcc_pkg::RSUM_W'(prod_r[c][a*3])
                        + rcc_pkg::RSUM_W'(prod_r[c][a*3 + 1])
                        + rcc_pkg::RSUM_W'(prod_r[c][a*3 + 2]);
        end
      end
      b2_fe_r <= b1_fe_r;
    end
  end

  // stage 3: total, shift, clamp
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = rcc_pkg::SUM_W'(rsum_r[c][0]) + rcc_pkg::SUM_W'(rsum_r[c][1])
             + rcc_pkg::SUM_W'(rsum_r[c][2]);
      shf[c] = sum[c] >> COEF_FRACTION_BITS;
      if (sum[c][rcc_pkg::SUM_W-1])                    clamp[c] = '0;
      else if (|shf[c][rcc_pkg::SUM_W-1:rcc_pkg::CH_W]) clamp[c] = '1;
      else                                             clamp[c] = shf[c][rcc_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data_r <= {clamp[2], clamp[1], clamp[0]};
      o_fe_r   <= b2_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      b1_v_r <= q_valid;
      b2_v_r <= b1_v_r;
      o_v_r  <= b2_v_r;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_fe_r;

endmodule

/* sv/rgb_convolution_3x3_clamp.sv */
// Top level of the RGB 3x3 convolution with zero padding and clamping.
// Instantiates rcc_front, rcc_fifo and rcc_back; uses rcc_pkg.
//
// Input stream: one item per pixel in raster order, or a drain item
// (in_tuser high). After the last pixel of a frame, image_width+1 items
// flush the remaining results; their data is ignored. Drain items before
// the last pixel are dropped. Output pixel n appears for input item
// n+image_width+1; out_tlast marks the last pixel of the frame.
// Configuration: cfg_index selects width, height or one kernel row;
// writes are taken at any time, always ready.
// Throughput: one item per clock while in_tready is high. The result of an
// accepted item reaches out_tdata through the line store read, the window
// into the queue, products, row sums, and total and clamp into the output.
// After reset or a width or height write, the block recomputes its row and
// column from the frame position by a shift-subtract divider (or restarts
// at position 0 if past the new frame's flush items); in_tready stays low until then.
// When the receiver stalls, the back pipeline holds and the 4-entry queue
// fills; in_tready drops once queue and front stage could overflow it.
module rgb_convolution_3x3_clamp #(
  parameter int MAX_WIDTH          = rcc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT         = rcc_pkg::MAX_HEIGHT_DEF,
  parameter int KERNEL_SIZE        = rcc_pkg::KERNEL_SIZE_DEF,
  parameter int COEF_FRACTION_BITS = rcc_pkg::COEF_FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rcc_pkg::PIX_W-1:0]      in_tdata,   // red_in, green_in, blue_in
  input  logic                           in_tuser,   // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rcc_pkg::PIX_W-1:0]      out_tdata,  // red_out, green_out, blue_out
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcc_pkg::KROW_W-1:0]     cfg_data
);

  rcc_pkg::cfg_wr_t     cfg;
  rcc_pkg::win_item_t   push_item, head;
  rcc_pkg::front_stat_t stat;
  logic push, pop, not_empty, acc;
  logic [rcc_pkg::CNT_W-1:0] count;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_tready = !stat.busy && !cfg_valid &&
                     (rcc_pkg::CNT_W + 1)'(count) + (rcc_pkg::CNT_W + 1)'(stat.inflight)
                       < (rcc_pkg::CNT_W + 1)'(rcc_pkg::FIFO_DEPTH);
  assign acc = in_tvalid && in_tready;

  rcc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg, .acc, .cmd(in_tuser), .pix(in_tdata),
    .push, .push_item, .stat
  );

  rcc_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .pop, .not_empty, .head, .count
  );

  rcc_back #(.KERNEL_SIZE(KERNEL_SIZE), .COEF_FRACTION_BITS(COEF_FRACTION_BITS)) u_back (
    .clk, .rst_n, .cfg, .q_valid(not_empty), .q_item(head), .q_pop(pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

/* sv/rcc_checker.sv */
// Port-level checks for the RGB 3x3 convolution block.
// Bound to rgb_convolution_3x3_clamp; uses rcc_pkg.
module rcc_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rcc_pkg::PIX_W-1:0]     out_tdata,
  input logic                          out_tlast,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("output valid or input ready right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == rcc_pkg::REG_WIDTH || cfg_index == rcc_pkg::REG_HEIGHT) |=> !in_tready)
    else $error("input accepted during geometry recompute");

endmodule

bind rgb_convolution_3x3_clamp rcc_port_checks u_rcc_port_checks (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast,
  .cfg_valid, .cfg_ready, .cfg_index
);

/* dv/rcc_checker.sv */
// Checker for the RGB 3x3 convolution: watches the input, result and configuration
// channels, predicts each filtered pixel and compares it field by field.
// Depends on rcc_pkg.
module rcc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [rcc_pkg::PIX_W-1:0]     in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [rcc_pkg::PIX_W-1:0]     out_tdata,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcc_pkg::KROW_W-1:0]    cfg_data,
  output int                            pending,
  output int                            errors
);

  localparam int LINE_D = 2048;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic [rcc_pkg::DIM_W-1:0]  width_reg, height_reg;
  logic [rcc_pkg::KROW_W-1:0] krow [3];
  logic [rcc_pkg::PIX_W-1:0]  upper_line [LINE_D];
  logic [rcc_pkg::PIX_W-1:0]  middle_line [LINE_D];
  logic [rcc_pkg::PIX_W-1:0]  win [3][3];
  int unsigned                in_pos;
  pixel_t                     filtered_q [$];

  assign pending = filtered_q.size();

  function automatic logic [7:0] clamp_sum(longint s);
    longint v;
    if (s < 0) return 8'd0;
    v = s >>> rcc_pkg::COEF_FRACTION_BITS_DEF;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic filter_item(logic cmd, logic [rcc_pkg::PIX_W-1:0] pix);
    int unsigned w, h, total, p, row, col, op, qr, qc;
    logic [rcc_pkg::PIX_W-1:0] top, mid, bot;
    logic signed [rcc_pkg::COEF_W-1:0] c;
    longint sum;
    logic [7:0] ch_val [3];
    pixel_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_D) ? LINE_D : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > LINE_D) ? LINE_D : height_reg);
    total = w * h;
    if (in_pos > total + w) in_pos = 0;
    p = in_pos;
    if (p < total && cmd) return;
    row = p / w;
    col = (p % w) & (LINE_D - 1);
    top = (row >= 2) ? upper_line[col] : '0;
    mid = (row >= 1) ? middle_line[col] : '0;
    bot = (p >= total) ? '0 : pix;
    upper_line[col] = mid;
    middle_line[col] = bot;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    in_pos = p + 1;
    if (p < w + 1) return;
    op = p - w - 1;
    qr = op / w;
    qc = op % w;
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int a = 0; a < 3; a++) begin
        if ((a == 0 && qr == 0) || (a == 2 && qr + 1 >= h)) continue;
        for (int b = 0; b < 3; b++) begin
          if ((b == 0 && qc == 0) || (b == 2 && qc + 1 >= w)) continue;
          c = krow[a][16*b +: 16];
          sum += longint'(win[a][b][8*k +: 8]) * longint'(c);
        end
      end
      ch_val[k] = clamp_sum(sum);
    end
    res.red = ch_val[0];
    res.green = ch_val[1];
    res.blue = ch_val[2];
    res.last = (op + 1 == total);
    if (res.last) in_pos = 0;
    filtered_q.push_back(res);
  endtask

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst_n) begin
      width_reg = rcc_pkg::WIDTH_RESET;
      height_reg = rcc_pkg::HEIGHT_RESET;
      krow[0] = rcc_pkg::KTOP_RESET;
      krow[1] = rcc_pkg::KMID_RESET;
      krow[2] = rcc_pkg::KBOT_RESET;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) win[a][b] = '0;
      in_pos = 0;
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result %h last %b", out_tdata, out_tlast);
          errors++;
        end else begin
          exp_px = filtered_q.pop_front();
          if (out_tdata[7:0] !== exp_px.red) begin
            $error("red_out expected %0d actual %0d", exp_px.red, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[15:8] !== exp_px.green) begin
            $error("green_out expected %0d actual %0d", exp_px.green, out_tdata[15:8]);
            errors++;
          end
          if (out_tdata[23:16] !== exp_px.blue) begin
            $error("blue_out expected %0d actual %0d", exp_px.blue, out_tdata[23:16]);
            errors++;
          end
          if (out_tlast !== exp_px.last) begin
            $error("frame_end expected %b actual %b", exp_px.last, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcc_pkg::REG_WIDTH:  width_reg = cfg_data[rcc_pkg::DIM_W-1:0];
          rcc_pkg::REG_HEIGHT: height_reg = cfg_data[rcc_pkg::DIM_W-1:0];
          rcc_pkg::REG_KTOP:   krow[0] = cfg_data;
          rcc_pkg::REG_KMID:   krow[1] = cfg_data;
          rcc_pkg::REG_KBOT:   krow[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) filter_item(in_tuser, in_tdata);
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for rgb_convolution_3x3_clamp: drives frames, drain items and
// register writes with random gaps and stalls, then gives the verdict.
// Depends on rcc_pkg, rcc_checker and the block itself.
module tb;

  localparam int LIMIT = 200000;
  localparam int SETTLE = 20;
  localparam int ITEMS = 650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rcc_pkg::PIX_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [rcc_pkg::PIX_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rcc_pkg::KROW_W-1:0] cfg_data = '0;
  int pending, errors;
  int cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  rgb_convolution_3x3_clamp u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  rcc_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .errors
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  task automatic send_item(logic cmd, logic [rcc_pkg::PIX_W-1:0] pix);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = pix;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending != 0);
    @(negedge clk);
  endtask

  task automatic write_reg(rcc_pkg::reg_idx_t idx, logic [rcc_pkg::KROW_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [rcc_pkg::KROW_W-1:0] rand_krow();
    logic [rcc_pkg::KROW_W-1:0] k;
    for (int i = 0; i < 3; i++)
      k[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 8192) - 4096);
    return k;
  endfunction

  function automatic logic [rcc_pkg::PIX_W-1:0] rand_pix();
    logic [rcc_pkg::PIX_W-1:0] p;
    p = rcc_pkg::PIX_W'($urandom);
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 5))
        0: p[8*i +: 8] = 8'd0;
        1: p[8*i +: 8] = 8'd255;
        default: ;
      endcase
    return p;
  endfunction

  task automatic set_geometry(int w, int h, logic [rcc_pkg::KROW_W-1:0] kt,
                              logic [rcc_pkg::KROW_W-1:0] km,
                              logic [rcc_pkg::KROW_W-1:0] kb);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    write_reg(rcc_pkg::REG_WIDTH, rcc_pkg::KROW_W'(w));
    write_reg(rcc_pkg::REG_HEIGHT, rcc_pkg::KROW_W'(h));
    write_reg(rcc_pkg::REG_KTOP, kt);
    write_reg(rcc_pkg::REG_KMID, km);
    write_reg(rcc_pkg::REG_KBOT, kb);
  endtask

  task automatic run_frame(int w, int h, int noise_pct, bit hold_mid);
    int ew, eh, total;
    ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
    eh = (h == 0) ? 1 : ((h > 2048) ? 2048 : h);
    total = ew * eh;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(1'b1, rand_pix());
      if (hold_mid && i == total / 2) wait_drained();
      send_item(1'b0, rand_pix());
    end
    for (int i = 0; i <= ew; i++) send_item(1'($urandom), rand_pix());
  endtask

  initial begin
    int w, h;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    calm = 1'b1;
    set_geometry(3, 2, rcc_pkg::KTOP_RESET, rcc_pkg::KMID_RESET, rcc_pkg::KBOT_RESET);
    send_item(1'b1, '1);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'hFF00FF);
    send_item(1'b0, 24'h00FF00);
    send_item(1'b1, 24'h123456);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    for (int i = 0; i < 4; i++) send_item(1'b0, rand_pix());
    calm = 1'b0;
    set_geometry(0, 0, rand_krow(), 48'h7FFF_7FFF_7FFF, rand_krow());
    run_frame(0, 0, 30, 1'b0);
    set_geometry(3, 3, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF, 48'h1000_1000_1000);
    run_frame(3, 3, 20, 1'b1);
    while (items_sent < ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      set_geometry(w, h, rand_krow(), rand_krow(), rand_krow());
      run_frame(w, h, $urandom_range(0, 15), $urandom_range(0, 7) == 0);
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* rgb_convolution_3x3_clamp.f */
sv/rcc_pkg.sv
sv/rcc_front.sv
sv/rcc_fifo.sv
sv/rcc_back.sv
sv/rgb_convolution_3x3_clamp.sv
sv/rcc_checker.sv
dv/rcc_checker.sv
dv/tb.sv
